// File: rtl/fsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants of the error-diffusion dither.
// -----------------------------------------------------------------------------
package fsd_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 12;
	localparam int EW_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
	localparam int PIX_W = 8;
	localparam int SUM_W = 11;
	localparam int PROD_W = SUM_W + 3;
	localparam int DIV_SHIFT = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = WIDTH_W'(600);
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(800);

	localparam logic signed [SUM_W-1:0] QUANT_LEVEL = SUM_W'(128);
	localparam logic signed [SUM_W-1:0] WHITE_SUM = SUM_W'(255);
	localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);
	localparam logic [PIX_W-1:0] PIX_BLACK = PIX_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH   = CFG_IDX_W'(0),
		REG_FRAME_HEIGHT = CFG_IDX_W'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic [EW_W-1:0]     width;
		logic [HEIGHT_W-1:0] height;
	} geom_t;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic             first;
		logic             row_nz;
		logic             has_right;
		logic             has_below;
	} pos_t;

endpackage
`default_nettype wire

// File: rtl/fsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsd_if
// Handshake channels of the dither: grey words in, dithered words out, and
// the configuration write channel.
// -----------------------------------------------------------------------------
interface fsd_grey_if;
	logic                     valid;
	logic                     ready;
	logic [fsd_pkg::PIX_W-1:0] grey_in;

	modport source (output valid, output grey_in, input ready);
	modport sink (input valid, input grey_in, output ready);
endinterface

interface fsd_bit_if;
	logic                     valid;
	logic                     ready;
	logic [fsd_pkg::PIX_W-1:0] bit_pixel;

	modport source (output valid, output bit_pixel, input ready);
	modport sink (input valid, input bit_pixel, output ready);
endinterface

interface fsd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fsd_pkg::CFG_IDX_W-1:0]  index;
	logic [fsd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsd_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module fsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/fsd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsd_cfg
// Geometry registers and their effective values.
// -----------------------------------------------------------------------------
module fsd_cfg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fsd_cfg_if.sink         cfg,
	output fsd_pkg::geom_t  geom
);

	logic [fsd_pkg::WIDTH_W-1:0]  line_width_q;
	logic [fsd_pkg::HEIGHT_W-1:0] frame_height_q;
	logic [fsd_pkg::EW_W-1:0]     lw_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= fsd_pkg::LINE_WIDTH_RST;
			frame_height_q <= fsd_pkg::FRAME_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				fsd_pkg::REG_LINE_WIDTH:   line_width_q <= cfg.data[fsd_pkg::WIDTH_W-1:0];
				fsd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg.data[fsd_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lw_ext = fsd_pkg::EW_W'(line_width_q);
		if (line_width_q == '0) begin
			geom.width = fsd_pkg::EW_W'(1);
		end else if (lw_ext > fsd_pkg::EW_W'(fsd_pkg::MAX_WIDTH)) begin
			geom.width = fsd_pkg::EW_W'(fsd_pkg::MAX_WIDTH);
		end else begin
			geom.width = lw_ext;
		end
		geom.height = (frame_height_q == '0) ? fsd_pkg::HEIGHT_W'(1) : frame_height_q;
	end

endmodule
`default_nettype wire

// File: rtl/fsd_pos.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsd_pos
// Raster position tracker: column and row of the next accepted word.
// -----------------------------------------------------------------------------
module fsd_pos (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fsd_pkg::geom_t  geom,
	input  wire logic            take,
	output fsd_pkg::pos_t        pos
);

	logic [fsd_pkg::COL_W-1:0]    col_q;
	logic [fsd_pkg::HEIGHT_W-1:0] row_q;
	logic                         wrap_col;
	logic [fsd_pkg::HEIGHT_W-1:0] row_a;
	logic [fsd_pkg::HEIGHT_W-1:0] row_b;
	logic [fsd_pkg::HEIGHT_W:0]   row_inc;

	always_comb begin
		wrap_col = fsd_pkg::EW_W'(col_q) >= geom.width;
		row_a = wrap_col ? row_q + fsd_pkg::HEIGHT_W'(1) : row_q;
		row_b = (row_a >= geom.height) ? '0 : row_a;
		pos.x = wrap_col ? '0 : col_q;
		pos.first = (pos.x == '0);
		pos.row_nz = (row_b != '0);
		pos.has_right = (fsd_pkg::EW_W'(pos.x) + fsd_pkg::EW_W'(1)) < geom.width;
		row_inc = {1'b0, row_b} + (fsd_pkg::HEIGHT_W + 1)'(1);
		pos.has_below = row_inc < {1'b0, geom.height};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (pos.has_right) begin
				col_q <= pos.x + fsd_pkg::COL_W'(1);
				row_q <= row_b;
			end else begin
				col_q <= '0;
				row_q <= pos.has_below ? row_inc[fsd_pkg::HEIGHT_W-1:0] : '0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/fsd_diffuse.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsd_diffuse
// Input register, quantizer with error spread, line-store write control and
// the result register.
// -----------------------------------------------------------------------------
module fsd_diffuse (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	fsd_grey_if.sink                         grey,
	fsd_bit_if.source                        mono,
	input  wire fsd_pkg::pos_t               pos,
	output logic                             take,
	output logic                             ram_we,
	output logic [fsd_pkg::COL_W-1:0]        ram_waddr,
	output logic [fsd_pkg::SUM_W-1:0]        ram_wdata,
	input  wire logic [fsd_pkg::SUM_W-1:0]   ram_rdata
);

	function automatic logic signed [fsd_pkg::SUM_W-1:0] div16(
		input logic signed [fsd_pkg::PROD_W-1:0] v
	);
		logic signed [fsd_pkg::PROD_W-1:0] t;
		t = v + (v[fsd_pkg::PROD_W-1] ? fsd_pkg::PROD_W'((1 << fsd_pkg::DIV_SHIFT) - 1)
			: fsd_pkg::PROD_W'(0));
		return fsd_pkg::SUM_W'(t >>> fsd_pkg::DIV_SHIFT);
	endfunction

	logic                             valid_s1;
	logic [fsd_pkg::PIX_W-1:0]        grey_s1;
	fsd_pkg::pos_t                    pos_s1;
	logic                             byp_s1;
	logic [fsd_pkg::SUM_W-1:0]        byp_data_s1;

	logic                             out_valid_q;
	logic [fsd_pkg::PIX_W-1:0]        bit_q;
	logic signed [fsd_pkg::SUM_W-1:0] rc_q;
	logic signed [fsd_pkg::SUM_W-1:0] pb0_q;
	logic signed [fsd_pkg::SUM_W-1:0] pb1_q;
	logic                             wb_valid_q;
	logic [fsd_pkg::COL_W-1:0]        wb_addr_q;
	logic [fsd_pkg::SUM_W-1:0]        wb_data_q;

	logic                             fire;
	logic signed [fsd_pkg::SUM_W-1:0] below;
	logic signed [fsd_pkg::SUM_W-1:0] rc_in;
	logic signed [fsd_pkg::SUM_W-1:0] pb0_in;
	logic signed [fsd_pkg::SUM_W-1:0] pb1_in;
	logic signed [fsd_pkg::SUM_W-1:0] sum;
	logic                             white;
	logic signed [fsd_pkg::SUM_W-1:0] err;
	logic signed [fsd_pkg::PROD_W-1:0] err_x;
	logic signed [fsd_pkg::SUM_W-1:0] d7;
	logic signed [fsd_pkg::SUM_W-1:0] d3;
	logic signed [fsd_pkg::SUM_W-1:0] d5;
	logic signed [fsd_pkg::SUM_W-1:0] d1;
	logic signed [fsd_pkg::SUM_W-1:0] pb0_n;
	logic signed [fsd_pkg::SUM_W-1:0] pb1_n;
	logic signed [fsd_pkg::SUM_W-1:0] left_val;
	logic                             we_left;
	logic                             we_here;

	assign fire = valid_s1 && (!out_valid_q || mono.ready);
	assign grey.ready = !valid_s1 || fire;
	assign take = grey.valid && grey.ready;
	assign mono.valid = out_valid_q;
	assign mono.bit_pixel = bit_q;

	always_comb begin
		if (!pos_s1.row_nz) begin
			below = '0;
		end else begin
			below = byp_s1 ? byp_data_s1 : ram_rdata;
		end
		rc_in  = pos_s1.first ? '0 : rc_q;
		pb0_in = pos_s1.first ? '0 : pb0_q;
		pb1_in = pos_s1.first ? '0 : pb1_q;
		sum = $signed({{(fsd_pkg::SUM_W - fsd_pkg::PIX_W){1'b0}}, grey_s1}) + rc_in + below;
		white = sum >= fsd_pkg::QUANT_LEVEL;
		err = white ? sum - fsd_pkg::WHITE_SUM : sum;
		err_x = fsd_pkg::PROD_W'(err);
		d7 = div16((err_x <<< 3) - err_x);
		d3 = div16((err_x <<< 1) + err_x);
		d5 = div16((err_x <<< 2) + err_x);
		d1 = div16(err_x);
		left_val = pb0_in + d3;
		pb0_n = pb1_in + d5;
		pb1_n = pos_s1.has_right ? d1 : '0;
		we_left = fire && pos_s1.has_below && (pos_s1.x != '0);
		we_here = fire && pos_s1.has_below && !pos_s1.has_right;

		if (we_left) begin
			ram_we = 1'b1;
			ram_waddr = pos_s1.x - fsd_pkg::COL_W'(1);
			ram_wdata = left_val;
		end else if (we_here) begin
			ram_we = 1'b1;
			ram_waddr = pos_s1.x;
			ram_wdata = pb0_n;
		end else begin
			ram_we = wb_valid_q;
			ram_waddr = wb_addr_q;
			ram_wdata = wb_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			wb_valid_q  <= 1'b0;
			rc_q        <= '0;
			pb0_q       <= '0;
			pb1_q       <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (mono.ready) begin
				out_valid_q <= 1'b0;
			end
			if (we_left && we_here) begin
				wb_valid_q <= 1'b1;
			end else if (!(we_left || we_here)) begin
				wb_valid_q <= 1'b0;
			end
			if (fire) begin
				rc_q  <= pos_s1.has_right ? d7 : '0;
				pb0_q <= pos_s1.has_below ? pb0_n : pb0_in;
				pb1_q <= pos_s1.has_below ? pb1_n : pb1_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grey_s1     <= grey.grey_in;
			pos_s1      <= pos;
			byp_s1      <= ram_we && (ram_waddr == pos.x);
			byp_data_s1 <= ram_wdata;
		end
		if (fire) begin
			bit_q <= white ? fsd_pkg::PIX_WHITE : fsd_pkg::PIX_BLACK;
		end
		if (we_left && we_here) begin
			wb_addr_q <= pos_s1.x;
			wb_data_q <= pb0_n;
		end
	end

`ifndef SYNTH
	a_wb_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_q |-> !(we_left || we_here))
		else $error("line-store write buffer overlaps a direct write");

	a_wb_drains: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_q |=> !wb_valid_q)
		else $error("line-store write buffer held for more than one cycle");

	a_out_binary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bit_q == fsd_pkg::PIX_WHITE || bit_q == fsd_pkg::PIX_BLACK))
		else $error("dithered word is neither black nor white");

	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |-> !take)
		else $error("word accepted while the input register is stalled");
`endif

endmodule
`default_nettype wire

// File: rtl/floyd_steinberg_dither.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// floyd_steinberg_dither
// Streaming error-diffusion dither of 8-bit grey words to black or white.
// -----------------------------------------------------------------------------
// The block takes one grey word per clock in raster order while the output is
// ready and returns one dithered word (0 or 255) per input, in order, via the
// input and result registers. Throughput is one word per cycle if not stalled,
// set by the loop that adds the carried right error into the next pixel and
// quantizes it. Next-row error sums live in a 1024-entry line store with
// registered read, so no reset clearing pass is needed: row zero ignores the
// store. Geometry registers must be written only while the block is idle.
module floyd_steinberg_dither (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fsd_cfg_if.sink    cfg,
	fsd_grey_if.sink   grey,
	fsd_bit_if.source  mono
);

	fsd_pkg::geom_t                geom;
	fsd_pkg::pos_t                 pos;
	logic                          take;
	logic                          ram_we;
	logic [fsd_pkg::COL_W-1:0]     ram_waddr;
	logic [fsd_pkg::SUM_W-1:0]     ram_wdata;
	logic [fsd_pkg::SUM_W-1:0]     ram_rdata;

	fsd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.geom   (geom)
	);

	fsd_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.take   (take),
		.pos    (pos)
	);

	fsd_ram #(
		.WIDTH (fsd_pkg::SUM_W),
		.DEPTH (fsd_pkg::MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (take),
		.raddr (pos.x),
		.rdata (ram_rdata)
	);

	fsd_diffuse u_diffuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.grey      (grey),
		.mono      (mono),
		.pos       (pos),
		.take      (take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

endmodule
`default_nettype wire
